[src/trq_pkg.sv]
// Package for the tag-allocating request queue: sizes, operation and status
// codes, FIFO entry and control types, pointer advance helper.
// No dependencies.
`default_nettype none

package trq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 6;
    localparam int HANDLE_W    = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd1;
    localparam logic [OP_W-1:0] OP_POP  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADTAG = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        idx_t                tag;
    } pend_entry_t;

    typedef struct packed {
        logic take;
        logic put;
    } fifo_req_t;

    function automatic idx_t ptr_adv(idx_t p);
        return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

[src/trq_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/trq_free_list.sv]
// Free tag FIFO: RAM plus head prefetch with write bypass; entries never
// written read as their own index. Depends on trq_pkg and trq_ram.
`default_nettype none

module trq_free_list
    import trq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fifo_req_t req,
    input  wire idx_t      put_tag,
    output idx_t           head_tag,
    output cnt_t           count
);

    idx_t head_reg, head_next;
    idx_t tail_reg, tail_next;
    cnt_t count_reg, count_next;
    logic wrap_reg, wrap_next;
    logic byp_reg, byp_next;
    logic init_reg, init_next;
    idx_t byp_data_reg;
    idx_t ram_rdata;

    always_comb
    begin
        head_next  = req.take ? ptr_adv(head_reg) : head_reg;
        tail_next  = req.put ? ptr_adv(tail_reg) : tail_reg;
        wrap_next  = wrap_reg || (req.put && (tail_reg == IDX_W'(QUEUE_DEPTH - 1)));
        count_next = count_reg + cnt_t'(req.put) - cnt_t'(req.take);
        byp_next   = req.put && (tail_reg == head_next);
        init_next  = !(wrap_reg || (head_next < tail_reg));
    end

    trq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.put),
        .waddr (tail_reg),
        .wdata (put_tag),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= CNT_W'(QUEUE_DEPTH);
            wrap_reg  <= 1'b0;
            byp_reg   <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            wrap_reg  <= wrap_next;
            byp_reg   <= byp_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= put_tag;
    end

    assign head_tag = byp_reg ? byp_data_reg : (init_reg ? head_reg : ram_rdata);
    assign count    = count_reg;

endmodule

`default_nettype wire

[src/trq_pending_queue.sv]
// Pending FIFO of tag and handle pairs: RAM plus head prefetch with write
// bypass. Depends on trq_pkg and trq_ram.
`default_nettype none

module trq_pending_queue
    import trq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fifo_req_t   req,
    input  wire pend_entry_t put_entry,
    output pend_entry_t      head_entry,
    output cnt_t             count
);

    idx_t        head_reg, head_next;
    idx_t        tail_reg, tail_next;
    cnt_t        count_reg, count_next;
    logic        byp_reg, byp_next;
    pend_entry_t byp_data_reg;
    pend_entry_t ram_rdata;

    always_comb
    begin
        head_next  = req.take ? ptr_adv(head_reg) : head_reg;
        tail_next  = req.put ? ptr_adv(tail_reg) : tail_reg;
        count_next = count_reg + cnt_t'(req.put) - cnt_t'(req.take);
        byp_next   = req.put && (tail_reg == head_next);
    end

    trq_ram #(
        .WIDTH ($bits(pend_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.put),
        .waddr (tail_reg),
        .wdata (put_entry),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= put_entry;
    end

    assign head_entry = byp_reg ? byp_data_reg : ram_rdata;
    assign count      = count_reg;

endmodule

`default_nettype wire

[src/tag_allocating_request_queue.sv]
// Tag-allocating request queue top level: operation decode, in-service
// flags and result register. Depends on trq_pkg, trq_free_list and
// trq_pending_queue.
//
// Usage:
//   Request channel (req_valid/req_ready) carries req_type, request_handle
//   and release_tag. Each item gives exactly one response on the response
//   channel (rsp_valid/rsp_ready) with status, tag and handle_out.
//   Push takes the oldest free tag and queues it as pending; peek dequeues
//   the oldest pending tag with its handle; pop returns an in-service tag
//   to the free list. Failed operations report a status and change nothing.
//   Response: registered, it shows in the cycle after accept.
//   Throughput: one item per cycle while responses are taken; an operation
//   moves at most one head and one tail on RAM FIFOs with prefetched heads.
//   Stall: req_ready follows the result register, so a stalled receiver
//   holds the response and blocks new items until it is taken.
//   Reset: all tags free in order 0 upward, nothing pending, no response.
`default_nettype none

module tag_allocating_request_queue
    import trq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [OP_W-1:0]     req_type,
    input  wire logic [HANDLE_W-1:0] request_handle,
    input  wire logic [TAG_W-1:0]    release_tag,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [TAG_W-1:0]         tag,
    output logic [HANDLE_W-1:0]      handle_out
);

    logic                   accept;
    logic                   push_ok, peek_ok, pop_ok;
    logic                   rel_in_range;
    idx_t                   rel_idx;
    idx_t                   free_head;
    cnt_t                   free_count, pend_count;
    pend_entry_t            pend_head, pend_put;
    fifo_req_t              free_req, pend_req;

    logic [QUEUE_DEPTH-1:0] svc_reg, svc_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign rel_in_range = 32'(release_tag) < 32'(QUEUE_DEPTH);
    assign rel_idx      = IDX_W'(release_tag);

    always_comb
    begin
        push_ok = accept && (req_type == OP_PUSH) && (free_count != '0)
                  && (pend_count < CNT_W'(QUEUE_DEPTH));
        peek_ok = accept && (req_type == OP_PEEK) && (pend_count != '0);
        pop_ok  = accept && (req_type == OP_POP) && rel_in_range && svc_reg[rel_idx]
                  && (free_count < CNT_W'(QUEUE_DEPTH));

        free_req.take   = push_ok;
        free_req.put    = pop_ok;
        pend_req.take   = peek_ok;
        pend_req.put    = push_ok;
        pend_put.tag    = free_head;
        pend_put.handle = request_handle;

        svc_next = svc_reg;
        if (peek_ok)
        begin
            svc_next[pend_head.tag] = 1'b1;
        end
        if (pop_ok)
        begin
            svc_next[rel_idx] = 1'b0;
        end

        status_next = ST_OK;
        tag_next    = '0;
        handle_next = '0;
        case (req_type)
            OP_PUSH:
            begin
                if (push_ok)
                begin
                    tag_next = TAG_W'(free_head);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_PEEK:
            begin
                if (peek_ok)
                begin
                    tag_next    = TAG_W'(pend_head.tag);
                    handle_next = pend_head.handle;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            OP_POP:
            begin
                if (!pop_ok)
                begin
                    status_next = ST_BADTAG;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    trq_free_list u_free (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (free_req),
        .put_tag  (rel_idx),
        .head_tag (free_head),
        .count    (free_count)
    );

    trq_pending_queue u_pend (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (pend_req),
        .put_entry  (pend_put),
        .head_entry (pend_head),
        .count      (pend_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            svc_reg       <= svc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            handle_reg <= handle_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign tag        = tag_reg;
    assign handle_out = handle_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Testbench for tag_allocating_request_queue: directed, pool-exhaustion, back-pressure
// and random request tests, checked item by item against an in-bench tag pool predictor.
// Depends on trq_pkg and the tag_allocating_request_queue RTL.
`timescale 1ns / 100ps

module testbench
    import trq_pkg::*;
();

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLDOFF_LEN  = 200;
    localparam int RANDOM_ITEMS = 1150;

    typedef enum int {TAG_FREE, TAG_PENDING, TAG_IN_SERVICE} tag_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } tag_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [OP_W-1:0]     req_type = OP_NOP;
    logic [HANDLE_W-1:0] request_handle = '0;
    logic [TAG_W-1:0]    release_tag = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle_out;

    logic [TAG_W-1:0]    free_tags [QUEUE_DEPTH];
    logic [TAG_W-1:0]    pend_tags [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] saved_handle [QUEUE_DEPTH];
    tag_phase_t          phase_of [QUEUE_DEPTH];
    int                  free_rd, free_wr, free_cnt;
    int                  pend_rd, pend_wr, pend_cnt;

    tag_result_t         result_q [$];
    int                  errors = 0;
    int                  stall_cycles = 0;
    int                  holdoff_cycles = 0;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;

    tag_allocating_request_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .request_handle (request_handle),
        .release_tag    (release_tag),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .tag            (tag),
        .handle_out     (handle_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic reset_pool();
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            free_tags[i]    = TAG_W'(i);
            pend_tags[i]    = '0;
            saved_handle[i] = '0;
            phase_of[i]     = TAG_FREE;
        end
        free_rd  = 0;
        free_wr  = 0;
        free_cnt = QUEUE_DEPTH;
        pend_rd  = 0;
        pend_wr  = 0;
        pend_cnt = 0;
    endtask

    function automatic tag_result_t apply_request(logic [OP_W-1:0] op,
                                                  logic [HANDLE_W-1:0] h,
                                                  logic [TAG_W-1:0] rel);
        tag_result_t r;
        logic [TAG_W-1:0] t;
        r = '{status: ST_OK, tag: '0, handle: '0};
        case (op)
            OP_PUSH:
            begin
                if (free_cnt == 0 || pend_cnt >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    t = free_tags[free_rd];
                    free_rd = (free_rd + 1) % QUEUE_DEPTH;
                    free_cnt--;
                    saved_handle[t] = h;
                    phase_of[t] = TAG_PENDING;
                    pend_tags[pend_wr] = t;
                    pend_wr = (pend_wr + 1) % QUEUE_DEPTH;
                    pend_cnt++;
                    r.tag = t;
                end
            end
            OP_PEEK:
            begin
                if (pend_cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    t = pend_tags[pend_rd];
                    pend_rd = (pend_rd + 1) % QUEUE_DEPTH;
                    pend_cnt--;
                    phase_of[t] = TAG_IN_SERVICE;
                    r.tag = t;
                    r.handle = saved_handle[t];
                end
            end
            OP_POP:
            begin
                if (int'(rel) >= QUEUE_DEPTH || phase_of[rel] != TAG_IN_SERVICE ||
                    free_cnt >= QUEUE_DEPTH)
                    r.status = ST_BADTAG;
                else
                begin
                    phase_of[rel] = TAG_FREE;
                    free_tags[free_wr] = rel;
                    free_wr = (free_wr + 1) % QUEUE_DEPTH;
                    free_cnt++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag_in_phase(tag_phase_t ph);
        logic [TAG_W-1:0] hits [$];
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (phase_of[i] == ph)
                hits.push_back(TAG_W'(i));
        if (hits.size() == 0)
            return TAG_W'($urandom_range(QUEUE_DEPTH - 1));
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                             logic [TAG_W-1:0] rel);
        if (tx_idle_en && $urandom_range(99) < 25)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_type       <= op;
        request_handle <= h;
        release_tag    <= rel;
        do
            @(posedge clk);
        while (!req_ready);
        result_q.push_back(apply_request(op, h, rel));
    endtask

    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            holdoff_cycles = holdoff_cycles - 1;
        end
        else if (rx_idle_en)
            rsp_ready <= ($urandom_range(99) >= 35);
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        tag_result_t exp_r;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d tag %0d handle %h",
                         $time, status, tag, handle_out);
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (status !== exp_r.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, status);
                end
                if (tag !== exp_r.tag)
                begin
                    errors++;
                    $display("%0t: tag expected %0d actual %0d",
                             $time, exp_r.tag, tag);
                end
                if (handle_out !== exp_r.handle)
                begin
                    errors++;
                    $display("%0t: handle_out expected %h actual %h",
                             $time, exp_r.handle, handle_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic test_basic_ops();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(OP_PEEK, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_POP, '0, 6'd0);
        send_item(OP_NOP, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_NOP, '0, '0);
        send_item(OP_PUSH, 32'h0000_0000, 6'd63);
        send_item(OP_PUSH, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_POP, '0, 6'd0);
        send_item(OP_PEEK, '0, '0);
        send_item(OP_POP, '0, 6'd0);
        send_item(OP_POP, '0, 6'd0);
        send_item(OP_POP, '0, 6'd63);
        send_item(OP_PEEK, '0, '0);
        send_item(OP_PEEK, '0, '0);
        send_item(OP_POP, 32'hFFFF_FFFF, 6'd1);
        send_item(OP_PUSH, 32'hA5A5_A5A5, 6'd42);
        send_item(OP_PUSH, 32'h5A5A_5A5A, 6'd21);
        send_item(OP_PEEK, '0, 6'd63);
        send_item(OP_POP, '0, 6'd63);
        send_item(OP_PEEK, '0, '0);
    endtask

    task automatic test_pool_exhaustion();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (free_cnt > 0)
            send_item(OP_PUSH, $urandom, TAG_W'($urandom));
        send_item(OP_PUSH, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_PUSH, 32'h0, 6'd0);
        send_item(OP_POP, '0, pick_tag_in_phase(TAG_PENDING));
        while (pend_cnt > 0)
            send_item(OP_PEEK, $urandom, TAG_W'($urandom));
        send_item(OP_PEEK, '0, '0);
        send_item(OP_PUSH, $urandom, '0);
        while (free_cnt < QUEUE_DEPTH)
            send_item(OP_POP, $urandom, pick_tag_in_phase(TAG_IN_SERVICE));
        send_item(OP_POP, '0, pick_tag_in_phase(TAG_FREE));
    endtask

    task automatic test_response_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        holdoff_cycles = HOLDOFF_LEN;
        for (int i = 0; i < 40; i++)
            send_item((i % 3 == 2) ? OP_PEEK : OP_PUSH, $urandom, TAG_W'($urandom));
    endtask

    task automatic test_random_traffic(int n_items);
        int bias;
        int roll;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 60 == 0)
                bias = $urandom_range(2);
            roll = $urandom_range(99);
            // bias 0 fills the pool, bias 1 drains it, bias 2 stays balanced
            if (roll < 8)
            begin
                if (roll < 2)
                    send_item(OP_NOP, $urandom, TAG_W'($urandom));
                else
                    send_item(OP_POP, $urandom, TAG_W'($urandom));
            end
            else if (roll < ((bias == 0) ? 70 : (bias == 1) ? 25 : 45))
                send_item(OP_PUSH, $urandom, TAG_W'($urandom));
            else if (roll < ((bias == 0) ? 85 : (bias == 1) ? 60 : 72))
                send_item(OP_PEEK, $urandom, TAG_W'($urandom));
            else
                send_item(OP_POP, $urandom, pick_tag_in_phase(TAG_IN_SERVICE));
        end
    endtask

    initial
    begin
        reset_pool();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_pool_exhaustion();
        test_response_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        req_valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
